/* sv/glyph_pixel_generator_unit_defines.svh */
// Assertion macros for the glyph pixel generator.
// Included by the top level; depends on nothing else.
`ifndef GLYPH_PIXEL_GENERATOR_UNIT_DEFINES_SVH
`define GLYPH_PIXEL_GENERATOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GPG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("glyph pixel generator: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define GPG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("glyph pixel generator: next-cycle check failed");

`endif

/* sv/gpg_pkg.sv */
// Shared types, constants, font ROM and helper functions for the glyph pixel generator.
// Used by the controller, the datapath and the top level; depends on nothing.
package gpg_pkg;

    localparam int GLYPH_COLUMNS = 5;
    localparam int GLYPH_ROWS    = 7;
    localparam int GLYPH_COUNT   = 44;
    localparam int GLYPH_MAX_DIM = (GLYPH_COLUMNS > GLYPH_ROWS) ? GLYPH_COLUMNS : GLYPH_ROWS;

    localparam int COORD_W  = 13;
    localparam int CODE_W   = 8;
    localparam int PSIZE_W  = 4;
    localparam int ADV_W    = 7;
    localparam int CFG_W    = 7;
    localparam int CFG_IDX_W = 1;
    localparam int MASK_W   = GLYPH_COLUMNS * GLYPH_ROWS;
    localparam int ROW_W    = $clog2(GLYPH_ROWS);
    localparam int MAX_OFF  = (GLYPH_MAX_DIM - 1) * ((1 << PSIZE_W) - 1);
    localparam int OFF_W    = $clog2(MAX_OFF + 1);

    localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_SIZE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAR_ADVANCE = 1'b1;

    localparam logic [PSIZE_W-1:0] PIXEL_SIZE_RESET   = 4'd2;
    localparam logic [ADV_W-1:0]   CHAR_ADVANCE_RESET = 7'd12;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } gpg_state_t;

    typedef struct packed {
        logic load;
        logic step;
    } gpg_cmd_t;

    typedef struct packed {
        logic known;
        logic out_free;
        logic last_step;
    } gpg_status_t;

    localparam logic [7:0] GLYPH_CODES [GLYPH_COUNT] = '{
        "A", "B", "C", "D", "E", "F", "G", "H", "I", "J", "K",
        "L", "M", "N", "O", "P", "Q", "R", "S", "T", "U", "V",
        "W", "X", "Y", "Z", "0", "1", "2", "3", "4", "5", "6",
        "7", "8", "9", ".", "-", ":", "/", "[", "]", "+", "%"
    };

    localparam logic [7:0] GLYPH_ROM [GLYPH_COUNT][8] = '{
        '{8'd126, 8'd17,  8'd17,  8'd17,  8'd126, 8'd0, 8'd0, 8'd0},
        '{8'd127, 8'd73,  8'd73,  8'd73,  8'd54,  8'd0, 8'd0, 8'd0},
        '{8'd62,  8'd65,  8'd65,  8'd65,  8'd34,  8'd0, 8'd0, 8'd0},
        '{8'd127, 8'd65,  8'd65,  8'd34,  8'd28,  8'd0, 8'd0, 8'd0},
        '{8'd127, 8'd73,  8'd73,  8'd73,  8'd65,  8'd0, 8'd0, 8'd0},
        '{8'd127, 8'd9,   8'd9,   8'd9,   8'd1,   8'd0, 8'd0, 8'd0},
        '{8'd62,  8'd65,  8'd73,  8'd73,  8'd122, 8'd0, 8'd0, 8'd0},
        '{8'd127, 8'd8,   8'd8,   8'd8,   8'd127, 8'd0, 8'd0, 8'd0},
        '{8'd0,   8'd65,  8'd127, 8'd65,  8'd0,   8'd0, 8'd0, 8'd0},
        '{8'd32,  8'd64,  8'd65,  8'd63,  8'd1,   8'd0, 8'd0, 8'd0},
        '{8'd127, 8'd8,   8'd20,  8'd34,  8'd65,  8'd0, 8'd0, 8'd0},
        '{8'd127, 8'd64,  8'd64,  8'd64,  8'd64,  8'd0, 8'd0, 8'd0},
        '{8'd127, 8'd2,   8'd12,  8'd2,   8'd127, 8'd0, 8'd0, 8'd0},
        '{8'd127, 8'd4,   8'd8,   8'd16,  8'd127, 8'd0, 8'd0, 8'd0},
        '{8'd62,  8'd65,  8'd65,  8'd65,  8'd62,  8'd0, 8'd0, 8'd0},
        '{8'd127, 8'd9,   8'd9,   8'd9,   8'd6,   8'd0, 8'd0, 8'd0},
        '{8'd62,  8'd65,  8'd81,  8'd33,  8'd94,  8'd0, 8'd0, 8'd0},
        '{8'd127, 8'd9,   8'd25,  8'd41,  8'd70,  8'd0, 8'd0, 8'd0},
        '{8'd70,  8'd73,  8'd73,  8'd73,  8'd49,  8'd0, 8'd0, 8'd0},
        '{8'd1,   8'd1,   8'd127, 8'd1,   8'd1,   8'd0, 8'd0, 8'd0},
        '{8'd63,  8'd64,  8'd64,  8'd64,  8'd63,  8'd0, 8'd0, 8'd0},
        '{8'd31,  8'd32,  8'd64,  8'd32,  8'd31,  8'd0, 8'd0, 8'd0},
        '{8'd63,  8'd64,  8'd56,  8'd64,  8'd63,  8'd0, 8'd0, 8'd0},
        '{8'd99,  8'd20,  8'd8,   8'd20,  8'd99,  8'd0, 8'd0, 8'd0},
        '{8'd7,   8'd8,   8'd112, 8'd8,   8'd7,   8'd0, 8'd0, 8'd0},
        '{8'd97,  8'd81,  8'd73,  8'd69,  8'd67,  8'd0, 8'd0, 8'd0},
        '{8'd62,  8'd81,  8'd73,  8'd69,  8'd62,  8'd0, 8'd0, 8'd0},
        '{8'd0,   8'd66,  8'd127, 8'd64,  8'd0,   8'd0, 8'd0, 8'd0},
        '{8'd66,  8'd97,  8'd81,  8'd73,  8'd70,  8'd0, 8'd0, 8'd0},
        '{8'd33,  8'd65,  8'd69,  8'd75,  8'd49,  8'd0, 8'd0, 8'd0},
        '{8'd24,  8'd20,  8'd18,  8'd127, 8'd16,  8'd0, 8'd0, 8'd0},
        '{8'd39,  8'd69,  8'd69,  8'd69,  8'd57,  8'd0, 8'd0, 8'd0},
        '{8'd60,  8'd74,  8'd73,  8'd73,  8'd48,  8'd0, 8'd0, 8'd0},
        '{8'd1,   8'd113, 8'd9,   8'd5,   8'd3,   8'd0, 8'd0, 8'd0},
        '{8'd54,  8'd73,  8'd73,  8'd73,  8'd54,  8'd0, 8'd0, 8'd0},
        '{8'd6,   8'd73,  8'd73,  8'd41,  8'd30,  8'd0, 8'd0, 8'd0},
        '{8'd0,   8'd96,  8'd96,  8'd0,   8'd0,   8'd0, 8'd0, 8'd0},
        '{8'd8,   8'd8,   8'd8,   8'd8,   8'd8,   8'd0, 8'd0, 8'd0},
        '{8'd0,   8'd54,  8'd54,  8'd0,   8'd0,   8'd0, 8'd0, 8'd0},
        '{8'd32,  8'd16,  8'd8,   8'd4,   8'd2,   8'd0, 8'd0, 8'd0},
        '{8'd0,   8'd127, 8'd65,  8'd65,  8'd0,   8'd0, 8'd0, 8'd0},
        '{8'd0,   8'd65,  8'd65,  8'd127, 8'd0,   8'd0, 8'd0, 8'd0},
        '{8'd8,   8'd8,   8'd62,  8'd8,   8'd8,   8'd0, 8'd0, 8'd0},
        '{8'd99,  8'd19,  8'd8,   8'd100, 8'd99,  8'd0, 8'd0, 8'd0}
    };

    // Returns the glyph as a flat dot mask, bit (column * GLYPH_ROWS + row).
    // Lower case letters are folded to upper case; unknown codes give an empty mask.
    function automatic logic [MASK_W-1:0] glyph_lookup(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] folded;
        logic [7:0]        cols [8];
        logic [MASK_W-1:0] mask;
        folded = code;
        if (code >= 8'h61 && code <= 8'h7a)
        begin
            folded = code - 8'h20;
        end
        for (int c = 0; c < 8; c++)
        begin
            cols[c] = 8'd0;
        end
        for (int g = 0; g < GLYPH_COUNT; g++)
        begin
            if (GLYPH_CODES[g] == folded)
            begin
                for (int c = 0; c < 8; c++)
                begin
                    cols[c] = cols[c] | GLYPH_ROM[g][c];
                end
            end
        end
        for (int c = 0; c < GLYPH_COLUMNS; c++)
        begin
            for (int r = 0; r < GLYPH_ROWS; r++)
            begin
                mask[c * GLYPH_ROWS + r] = cols[c][r];
            end
        end
        return mask;
    endfunction

    // Adds two coordinates and saturates at the largest coordinate.
    function automatic logic [COORD_W-1:0] sat_add(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
        logic [COORD_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[COORD_W] ? COORD_MAX : sum[COORD_W-1:0];
    endfunction

endpackage

/* sv/gpg_ctrl.sv */
// Controller state machine of the glyph pixel generator.
// Depends on gpg_pkg; drives commands to gpg_datapath and the input stall.
module gpg_ctrl
    import gpg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  gpg_status_t status,
    output gpg_cmd_t    cmd
);

    gpg_state_t state_reg;
    gpg_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (status.known)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (status.out_free)
                begin
                    cmd.step = 1'b1;
                    if (status.last_step)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* sv/gpg_datapath.sv */
// Datapath of the glyph pixel generator: configuration, cursor, glyph scan and output register.
// Depends on gpg_pkg; commanded by gpg_ctrl.
module gpg_datapath
    import gpg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic [CODE_W-1:0]    char_code,
    input  logic                 string_start,
    input  logic [COORD_W-1:0]   start_x,
    input  logic [COORD_W-1:0]   start_y,
    input  gpg_cmd_t             cmd,
    output gpg_status_t          status,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [COORD_W-1:0]   dot_x,
    output logic [COORD_W-1:0]   dot_y,
    output logic                 last_dot
);

    logic [PSIZE_W-1:0] pixel_size_reg, pixel_size_next;
    logic [ADV_W-1:0]   char_advance_reg, char_advance_next;
    logic [COORD_W-1:0] cursor_x_reg, cursor_x_next;
    logic [COORD_W-1:0] cursor_y_reg, cursor_y_next;
    logic [COORD_W-1:0] base_x_reg, base_x_next;
    logic [COORD_W-1:0] base_y_reg, base_y_next;
    logic [MASK_W-1:0]  mask_reg, mask_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [OFF_W-1:0]   x_off_reg, x_off_next;
    logic [OFF_W-1:0]   y_off_reg, y_off_next;
    logic               out_valid_reg, out_valid_next;
    logic [COORD_W-1:0] dot_x_reg, dot_x_next;
    logic [COORD_W-1:0] dot_y_reg, dot_y_next;
    logic               last_dot_reg, last_dot_next;

    logic [MASK_W-1:0]  lookup_mask;
    logic [COORD_W-1:0] sel_x;
    logic [COORD_W-1:0] sel_y;
    logic               out_free;

    assign lookup_mask = glyph_lookup(char_code);
    assign sel_x       = string_start ? start_x : cursor_x_reg;
    assign sel_y       = string_start ? start_y : cursor_y_reg;
    assign out_free    = !out_valid_reg || !out_stall;

    assign status.known     = |lookup_mask;
    assign status.out_free  = out_free;
    assign status.last_step = (mask_reg >> 1) == '0;

    always_comb
    begin
        pixel_size_next   = pixel_size_reg;
        char_advance_next = char_advance_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_PIXEL_SIZE:   pixel_size_next   = cfg_data[PSIZE_W-1:0];
                CFG_CHAR_ADVANCE: char_advance_next = cfg_data[ADV_W-1:0];
                default:          pixel_size_next   = pixel_size_reg;
            endcase
        end
    end

    always_comb
    begin
        cursor_x_next  = cursor_x_reg;
        cursor_y_next  = cursor_y_reg;
        base_x_next    = base_x_reg;
        base_y_next    = base_y_reg;
        mask_next      = mask_reg;
        row_next       = row_reg;
        x_off_next     = x_off_reg;
        y_off_next     = y_off_reg;
        out_valid_next = out_valid_reg;
        dot_x_next     = dot_x_reg;
        dot_y_next     = dot_y_reg;
        last_dot_next  = last_dot_reg;

        if (cmd.load)
        begin
            base_x_next   = sel_x;
            base_y_next   = sel_y;
            cursor_x_next = sat_add(sel_x, COORD_W'(char_advance_reg));
            cursor_y_next = sel_y;
            mask_next     = lookup_mask;
            row_next      = '0;
            x_off_next    = '0;
            y_off_next    = '0;
        end

        if (out_free)
        begin
            out_valid_next = cmd.step && mask_reg[0];
        end

        if (cmd.step)
        begin
            mask_next = mask_reg >> 1;
            if (mask_reg[0])
            begin
                dot_x_next    = sat_add(base_x_reg, COORD_W'(x_off_reg));
                dot_y_next    = sat_add(base_y_reg, COORD_W'(y_off_reg));
                last_dot_next = status.last_step;
            end
            if (row_reg == ROW_W'(GLYPH_ROWS - 1))
            begin
                row_next   = '0;
                y_off_next = '0;
                x_off_next = x_off_reg + OFF_W'(pixel_size_reg);
            end
            else
            begin
                row_next   = row_reg + 1'b1;
                y_off_next = y_off_reg + OFF_W'(pixel_size_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_size_reg   <= PIXEL_SIZE_RESET;
            char_advance_reg <= CHAR_ADVANCE_RESET;
            cursor_x_reg     <= '0;
            cursor_y_reg     <= '0;
            mask_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            pixel_size_reg   <= pixel_size_next;
            char_advance_reg <= char_advance_next;
            cursor_x_reg     <= cursor_x_next;
            cursor_y_reg     <= cursor_y_next;
            mask_reg         <= mask_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_x_reg   <= base_x_next;
        base_y_reg   <= base_y_next;
        row_reg      <= row_next;
        x_off_reg    <= x_off_next;
        y_off_reg    <= y_off_next;
        dot_x_reg    <= dot_x_next;
        dot_y_reg    <= dot_y_next;
        last_dot_reg <= last_dot_next;
    end

    assign out_valid = out_valid_reg;
    assign dot_x     = dot_x_reg;
    assign dot_y     = dot_y_reg;
    assign last_dot  = last_dot_reg;

endmodule

/* sv/glyph_pixel_generator_unit.sv */
// A dot enters the output register at the end of the scan step that reaches its position; the glyph
// mask is registered first, and each blank position before a dot delays it. The input is stalled
// while a known character is scanned up to its last set dot, the scan holding while the output stalls,
// and the next character is taken while that last dot may still wait; an unknown one needs no scan.
// Reset is asynchronous and active low: it clears the cursor, loads pixel_size 2 and
// char_advance 12, and leaves the block idle with no result pending.
`include "glyph_pixel_generator_unit_defines.svh"

module glyph_pixel_generator_unit
    import gpg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [CODE_W-1:0]    char_code,
    input  logic                 string_start,
    input  logic [COORD_W-1:0]   start_x,
    input  logic [COORD_W-1:0]   start_y,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [COORD_W-1:0]   dot_x,
    output logic [COORD_W-1:0]   dot_y,
    output logic                 last_dot
);

    gpg_cmd_t    cmd;
    gpg_status_t status;

    gpg_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    gpg_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .char_code    (char_code),
        .string_start (string_start),
        .start_x      (start_x),
        .start_y      (start_y),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .dot_x        (dot_x),
        .dot_y        (dot_y),
        .last_dot     (last_dot)
    );

    `GPG_ASSERT_SAME(a_load_on_transfer, clk, rst_n, cmd.load, in_valid && !in_stall)
    `GPG_ASSERT_SAME(a_step_needs_room, clk, rst_n, cmd.step, !out_valid || !out_stall)
    `GPG_ASSERT_NEXT(a_known_goes_busy, clk, rst_n,
        in_valid && !in_stall && status.known, in_stall)

endmodule

/* dv/glyph_checker.sv */
`timescale 1ns / 100ps
// Dot checker for the glyph pixel generator: follows register writes and character transfers,
// predicts every dot from its own font table and compares each dot transfer in order.
// Depends on gpg_pkg for port widths, register indexes and reset values.
module glyph_checker
    import gpg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [CODE_W-1:0]    char_code,
    input  logic                 string_start,
    input  logic [COORD_W-1:0]   start_x,
    input  logic [COORD_W-1:0]   start_y,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [COORD_W-1:0]   dot_x,
    input  logic [COORD_W-1:0]   dot_y,
    input  logic                 last_dot,
    output int                   fail_count,
    output int                   dots_waiting,
    output int                   dots_checked
);

    localparam int FONT_SIZE = 44;
    localparam logic [8*FONT_SIZE-1:0] FONT_CHARS = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.-:/[]+%";
    localparam logic [8*5*FONT_SIZE-1:0] FONT_COLUMN_BYTES = {
        8'd126, 8'd17, 8'd17, 8'd17, 8'd126,   8'd127, 8'd73, 8'd73, 8'd73, 8'd54,
        8'd62, 8'd65, 8'd65, 8'd65, 8'd34,     8'd127, 8'd65, 8'd65, 8'd34, 8'd28,
        8'd127, 8'd73, 8'd73, 8'd73, 8'd65,    8'd127, 8'd9, 8'd9, 8'd9, 8'd1,
        8'd62, 8'd65, 8'd73, 8'd73, 8'd122,    8'd127, 8'd8, 8'd8, 8'd8, 8'd127,
        8'd0, 8'd65, 8'd127, 8'd65, 8'd0,      8'd32, 8'd64, 8'd65, 8'd63, 8'd1,
        8'd127, 8'd8, 8'd20, 8'd34, 8'd65,     8'd127, 8'd64, 8'd64, 8'd64, 8'd64,
        8'd127, 8'd2, 8'd12, 8'd2, 8'd127,     8'd127, 8'd4, 8'd8, 8'd16, 8'd127,
        8'd62, 8'd65, 8'd65, 8'd65, 8'd62,     8'd127, 8'd9, 8'd9, 8'd9, 8'd6,
        8'd62, 8'd65, 8'd81, 8'd33, 8'd94,     8'd127, 8'd9, 8'd25, 8'd41, 8'd70,
        8'd70, 8'd73, 8'd73, 8'd73, 8'd49,     8'd1, 8'd1, 8'd127, 8'd1, 8'd1,
        8'd63, 8'd64, 8'd64, 8'd64, 8'd63,     8'd31, 8'd32, 8'd64, 8'd32, 8'd31,
        8'd63, 8'd64, 8'd56, 8'd64, 8'd63,     8'd99, 8'd20, 8'd8, 8'd20, 8'd99,
        8'd7, 8'd8, 8'd112, 8'd8, 8'd7,        8'd97, 8'd81, 8'd73, 8'd69, 8'd67,
        8'd62, 8'd81, 8'd73, 8'd69, 8'd62,     8'd0, 8'd66, 8'd127, 8'd64, 8'd0,
        8'd66, 8'd97, 8'd81, 8'd73, 8'd70,     8'd33, 8'd65, 8'd69, 8'd75, 8'd49,
        8'd24, 8'd20, 8'd18, 8'd127, 8'd16,    8'd39, 8'd69, 8'd69, 8'd69, 8'd57,
        8'd60, 8'd74, 8'd73, 8'd73, 8'd48,     8'd1, 8'd113, 8'd9, 8'd5, 8'd3,
        8'd54, 8'd73, 8'd73, 8'd73, 8'd54,     8'd6, 8'd73, 8'd73, 8'd41, 8'd30,
        8'd0, 8'd96, 8'd96, 8'd0, 8'd0,        8'd8, 8'd8, 8'd8, 8'd8, 8'd8,
        8'd0, 8'd54, 8'd54, 8'd0, 8'd0,        8'd32, 8'd16, 8'd8, 8'd4, 8'd2,
        8'd0, 8'd127, 8'd65, 8'd65, 8'd0,      8'd0, 8'd65, 8'd65, 8'd127, 8'd0,
        8'd8, 8'd8, 8'd62, 8'd8, 8'd8,         8'd99, 8'd19, 8'd8, 8'd100, 8'd99
    };

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
    } dot_t;

    dot_t               dot_q [$];
    logic [PSIZE_W-1:0] dot_pitch;
    logic [ADV_W-1:0]   advance;
    logic [COORD_W-1:0] pen_x;
    logic [COORD_W-1:0] pen_y;

    function automatic logic [COORD_W-1:0] clamp_coord(input int unsigned a, input int unsigned b);
        int unsigned s;
        s = a + b;
        return (s > COORD_MAX) ? COORD_MAX : s[COORD_W-1:0];
    endfunction

    task automatic plan_char(input logic [CODE_W-1:0] code, input logic load,
                             input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy);
        logic [7:0] folded;
        logic [7:0] column;
        int         glyph;
        dot_t       held;
        bit         have_held;
        folded = code;
        glyph = -1;
        have_held = 1'b0;
        held = '0;
        if (load)
        begin
            pen_x = sx;
            pen_y = sy;
        end
        if (code >= "a" && code <= "z")
        begin
            folded = code - 8'd32;
        end
        for (int i = 0; i < FONT_SIZE; i++)
        begin
            if (FONT_CHARS[8*(FONT_SIZE-1-i) +: 8] == folded)
            begin
                glyph = i;
            end
        end
        if (glyph >= 0)
        begin
            for (int col = 0; col < GLYPH_COLUMNS; col++)
            begin
                column = FONT_COLUMN_BYTES[8*(5*FONT_SIZE-1-(5*glyph+col)) +: 8];
                for (int row = 0; row < GLYPH_ROWS; row++)
                begin
                    if (column[row])
                    begin
                        if (have_held)
                        begin
                            dot_q.push_back(held);
                        end
                        held.x = clamp_coord(pen_x, col * dot_pitch);
                        held.y = clamp_coord(pen_y, row * dot_pitch);
                        held.last = 1'b0;
                        have_held = 1'b1;
                    end
                end
            end
        end
        if (have_held)
        begin
            held.last = 1'b1;
            dot_q.push_back(held);
        end
        pen_x = clamp_coord(pen_x, advance);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        dot_t want;
        if (!rst_n)
        begin
            dot_pitch = PIXEL_SIZE_RESET;
            advance = CHAR_ADVANCE_RESET;
            pen_x = '0;
            pen_y = '0;
            dot_q.delete();
            fail_count = 0;
            dots_checked = 0;
            dots_waiting <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_PIXEL_SIZE)
                begin
                    dot_pitch = cfg_data[PSIZE_W-1:0];
                end
                else if (cfg_index == CFG_CHAR_ADVANCE)
                begin
                    advance = cfg_data[ADV_W-1:0];
                end
            end
            if (in_valid && !in_stall)
            begin
                plan_char(char_code, string_start, start_x, start_y);
            end
            if (out_valid && !out_stall)
            begin
                if (dot_q.size() == 0)
                begin
                    $error("unexpected dot transfer: dot_x %0d dot_y %0d", dot_x, dot_y);
                    fail_count++;
                end
                else
                begin
                    want = dot_q.pop_front();
                    if (dot_x !== want.x)
                    begin
                        $error("dot_x expected %0d, got %0d", want.x, dot_x);
                        fail_count++;
                    end
                    if (dot_y !== want.y)
                    begin
                        $error("dot_y expected %0d, got %0d", want.y, dot_y);
                        fail_count++;
                    end
                    if (last_dot !== want.last)
                    begin
                        $error("last_dot expected %0d, got %0d", want.last, last_dot);
                        fail_count++;
                    end
                    dots_checked++;
                end
            end
            dots_waiting <= dot_q.size();
        end
    end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// Top of the glyph pixel generator testbench: clock, reset, register writes, character
// stimulus in bursts and a stalling dot receiver. Depends on gpg_pkg and glyph_checker.
module tb_top;
    import gpg_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 40;
    localparam logic [8*8-1:0] PUNCTUATION = ".-:/[]+%";

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [CFG_W-1:0]     cfg_data     = '0;
    logic                 in_valid     = 1'b0;
    logic [CODE_W-1:0]    char_code    = '0;
    logic                 string_start = 1'b0;
    logic [COORD_W-1:0]   start_x      = '0;
    logic [COORD_W-1:0]   start_y      = '0;
    logic                 out_stall    = 1'b0;
    logic                 in_stall;
    logic                 out_valid;
    logic [COORD_W-1:0]   dot_x;
    logic [COORD_W-1:0]   dot_y;
    logic                 last_dot;

    int fail_count;
    int dots_waiting;
    int dots_checked;
    int burst_left  = 0;
    int string_left = 0;
    int chars_sent  = 0;
    int cycles      = 0;
    int stall_left  = 0;

    glyph_pixel_generator_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_code    (char_code),
        .string_start (string_start),
        .start_x      (start_x),
        .start_y      (start_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .dot_x        (dot_x),
        .dot_y        (dot_y),
        .last_dot     (last_dot)
    );

    glyph_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_code    (char_code),
        .string_start (string_start),
        .start_x      (start_x),
        .start_y      (start_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .dot_x        (dot_x),
        .dot_y        (dot_y),
        .last_dot     (last_dot),
        .fail_count   (fail_count),
        .dots_waiting (dots_waiting),
        .dots_checked (dots_checked)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
        end
        else
        begin
            case ($urandom_range(0, 4))
                0, 1, 2:
                begin
                    out_stall <= 1'b0;
                    stall_left <= $urandom_range(0, 40);
                end
                3:
                begin
                    out_stall <= 1'b1;
                    stall_left <= $urandom_range(0, 2);
                end
                default:
                begin
                    out_stall <= 1'b1;
                    stall_left <= $urandom_range(3, 12);
                end
            endcase
        end
    end

    function automatic logic [CODE_W-1:0] pick_code();
        logic [CODE_W-1:0] code;
        code = CODE_W'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            0, 1, 2, 3: code = CODE_W'("A" + $urandom_range(0, 25)
                                       + (($urandom_range(0, 2) == 0) ? 32 : 0));
            4, 5:       code = CODE_W'("0" + $urandom_range(0, 9));
            6:          code = PUNCTUATION[8*$urandom_range(0, 7) +: 8];
            7:          code = " ";
            default:    ;
        endcase
        return code;
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord();
        logic [COORD_W-1:0] coord;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: coord = COORD_W'($urandom_range(0, 1023));
            6, 7:             coord = COORD_W'($urandom_range(7800, 8191));
            default:          coord = COORD_W'($urandom);
        endcase
        return coord;
    endfunction

    task automatic send_char(input logic [CODE_W-1:0] code, input logic load,
                             input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
        burst_left--;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        char_code <= code;
        string_start <= load;
        start_x <= sx;
        start_y <= sy;
        do @(posedge clk); while (in_stall);
        chars_sent++;
    endtask

    task automatic send_text(input int count);
        logic load;
        for (int k = 0; k < count; k++)
        begin
            load = 1'b0;
            if (string_left == 0)
            begin
                load = 1'b1;
                string_left = $urandom_range(1, 14);
            end
            string_left--;
            send_char(pick_code(), load, pick_coord(), pick_coord());
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (dots_waiting != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input logic [CFG_W-1:0] pitch, input logic [CFG_W-1:0] step);
        cfg_we <= 1'b1;
        cfg_index <= CFG_PIXEL_SIZE;
        cfg_data <= pitch;
        @(posedge clk);
        cfg_index <= CFG_CHAR_ADVANCE;
        cfg_data <= step;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_char("A", 1'b1, 13'd0, 13'd0);
        send_char("%", 1'b0, 13'd0, 13'd0);
        send_char("z", 1'b0, 13'd0, 13'd0);
        send_char(" ", 1'b0, 13'd0, 13'd0);
        send_char(8'h00, 1'b0, 13'd0, 13'd0);
        send_char(8'hFF, 1'b1, 13'd8191, 13'd8191);
        send_char("M", 1'b0, 13'd8191, 13'd8191);
        send_char("8", 1'b1, 13'd8180, 13'd8185);
        send_char("W", 1'b0, 13'd0, 13'd0);
        send_char(8'h80, 1'b0, 13'd0, 13'd0);
        send_char("a", 1'b0, 13'd0, 13'd0);
        send_char("0", 1'b0, 13'd0, 13'd0);
        send_char("[", 1'b1, 13'd5461, 13'd2730);
        send_char("]", 1'b0, 13'd2730, 13'd5461);
        send_char(".", 1'b0, 13'd0, 13'd0);
        send_char("-", 1'b0, 13'd0, 13'd0);
        send_char(":", 1'b0, 13'd0, 13'd0);
        send_char("/", 1'b0, 13'd0, 13'd0);
        send_char("+", 1'b0, 13'd0, 13'd0);
        send_char("9", 1'b0, 13'd0, 13'd0);
        send_char("i", 1'b0, 13'd0, 13'd0);
        send_char(8'h7F, 1'b0, 13'd0, 13'd0);
        send_char("Q", 1'b0, 13'd0, 13'd0);
        settle();

        write_regs(7'd15, 7'd127);
        send_text(110);
        settle();
        write_regs(7'd0, 7'd0);
        send_text(30);
        settle();
        write_regs(7'd1, 7'd1);
        send_text(100);
        settle();
        repeat (2)
        begin
            write_regs(CFG_W'($urandom_range(1, 15)), CFG_W'($urandom_range(1, 127)));
            send_text(80);
            settle();
        end

        $display("Run covered %0d characters and %0d checked dots over six register settings,",
                 chars_sent, dots_checked);
        $display("including zero and full-scale dot size and advance, and coordinate saturation.");
        if (fail_count == 0)
        begin
            $display("tb_top: clean");
        end
        else
        begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
